// ===== rtl/grw_pkg.sv =====
// shared types and constants for the grid ray wall hit block
package grw_pkg;

  localparam int unsigned MAP_SIDE_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 10;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned CELL_W  = 6;
  localparam int unsigned CFG_W   = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN_A,
    ST_LEN_B,
    ST_LEN_C,
    ST_DIST_A,
    ST_DIST_B,
    ST_DIST_C,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_C,
    ST_DIV,
    ST_STEP,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    MUL_VX,
    MUL_VY,
    MUL_DX,
    MUL_DY,
    MUL_XA,
    MUL_YA
  } mul_sel_e;

  typedef struct packed {
    logic     clr_wr;
    logic     cell_wr;
    logic     item_ld;
    mul_sel_e mul_sel;
    logic     acc_ld;
    logic     len_ld;
    logic     div_ld;
    logic     div_step;
    logic     upd;
    logic     out_ld;
    logic     out_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic dist_ok;
    logic wall;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/grw_ctrl.sv =====
// controller state machine sequencing the clear pass, map writes and traces
module grw_ctrl import grw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   hit_q, hit_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc && operation_i == OP_TRACE) state_d = ST_LEN_A;
      ST_LEN_A:  state_d = ST_LEN_B;
      ST_LEN_B:  state_d = ST_LEN_C;
      ST_LEN_C:  state_d = ST_DIST_A;
      ST_DIST_A: state_d = ST_DIST_B;
      ST_DIST_B: state_d = ST_DIST_C;
      ST_DIST_C: begin
        if (!status_i.dist_ok || status_i.wall) state_d = ST_FIN;
        else state_d = ST_CMP_A;
      end
      ST_CMP_A:  state_d = ST_CMP_B;
      ST_CMP_B:  state_d = ST_CMP_C;
      ST_CMP_C:  state_d = ST_DIV;
      ST_DIV:    if (status_i.div_done) state_d = ST_STEP;
      ST_STEP:   state_d = ST_DIST_A;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_VX;
    cmd_o.out_hit = hit_q;
    hit_d         = hit_q;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        cmd_o.cell_wr = in_acc && (operation_i == OP_WRITE);
        cmd_o.item_ld = in_acc && (operation_i == OP_TRACE);
      end
      ST_LEN_A:  cmd_o.mul_sel = MUL_VX;
      ST_LEN_B: begin
        cmd_o.mul_sel = MUL_VY;
        cmd_o.acc_ld  = 1'b1;
      end
      ST_LEN_C:  cmd_o.len_ld = 1'b1;
      ST_DIST_A: cmd_o.mul_sel = MUL_DX;
      ST_DIST_B: begin
        cmd_o.mul_sel = MUL_DY;
        cmd_o.acc_ld  = 1'b1;
      end
      ST_DIST_C: hit_d = status_i.dist_ok && status_i.wall;
      ST_CMP_A:  cmd_o.mul_sel = MUL_XA;
      ST_CMP_B: begin
        cmd_o.mul_sel = MUL_YA;
        cmd_o.acc_ld  = 1'b1;
      end
      ST_CMP_C:  cmd_o.div_ld = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_STEP:   cmd_o.upd = 1'b1;
      ST_FIN: begin
        cmd_o.out_ld = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/grw_datapath.sv =====
// datapath: wall map memory, walk registers, shared multiplier and divider
module grw_datapath import grw_pkg::*; #(
  parameter int unsigned MAP_SIDE  = MAP_SIDE_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic [CELL_W-1:0]  cell_x_i,
  input  logic [CELL_W-1:0]  cell_y_i,
  input  logic               cell_blocked_i,
  input  logic [COORD_W-1:0] from_x_i,
  input  logic [COORD_W-1:0] from_y_i,
  input  logic [COORD_W-1:0] to_x_i,
  input  logic [COORD_W-1:0] to_y_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic               hit_o,
  output logic [COORD_W-1:0] end_x_o,
  output logic [COORD_W-1:0] end_y_o
);

  localparam int unsigned AW    = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam int unsigned DEPTH = 1 << (2 * AW);
  localparam int unsigned CW    = COORD_W - FRAC_BITS + 2;
  localparam int unsigned CMPW  = (CW > 12) ? CW + 1 : 13;
  localparam int unsigned PW    = 19;
  localparam int unsigned MW    = PW + 1;
  localparam int unsigned PRW   = 2 * MW;
  localparam int unsigned VW    = COORD_W + 1;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned NW    = COORD_W + QW;
  localparam int unsigned DCW   = $clog2(QW + 1);

  localparam logic signed [CW-1:0] ONE_C = CW'(1);
  localparam logic signed [CW-1:0] NEG_C = CW'(-1);

  function automatic logic [COORD_W-1:0] clamp16(input logic signed [PW-1:0] v);
    logic [COORD_W-1:0] r;
    if (v[PW-1]) r = '0;
    else if (|v[PW-2:COORD_W]) r = '1;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0] map_width_q, map_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= CFG_RESET;
      map_height_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MAP_WIDTH) map_width_q <= cfg_data_i;
      if (cfg_index_i == CFG_MAP_HEIGHT) map_height_q <= cfg_data_i;
    end
  end

  // wall map
  logic                wall_mem [DEPTH];
  logic [2*AW-1:0]     clr_cnt_q;
  logic                mem_rd_q;
  logic                mem_we, mem_wd;
  logic [2*AW-1:0]     mem_wa, mem_ra;
  logic [CMPW-1:0]     wx_ext, wy_ext;
  logic                wr_in_range;

  assign wx_ext      = CMPW'(cell_x_i);
  assign wy_ext      = CMPW'(cell_y_i);
  assign wr_in_range = (wx_ext < CMPW'(MAP_SIDE)) && (wy_ext < CMPW'(MAP_SIDE));
  assign mem_we      = cmd_i.clr_wr || (cmd_i.cell_wr && wr_in_range);
  assign mem_wd      = cmd_i.clr_wr ? 1'b0 : cell_blocked_i;
  assign mem_wa      = cmd_i.clr_wr ? clr_cnt_q : {wy_ext[AW-1:0], wx_ext[AW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) wall_mem[mem_wa] <= mem_wd;
    mem_rd_q <= wall_mem[mem_ra];
  end

  // walk state
  logic signed [PW-1:0]  fx_q, fy_q, px_q, py_q;
  logic [COORD_W-1:0]    tx_q, ty_q;
  logic signed [VW-1:0]  vx_q, vy_q;
  logic                  sx_q, sy_q;
  logic signed [CW-1:0]  cx_q, cy_q, bx_q, by_q;

  logic signed [VW-1:0]  vx_in, vy_in, vx_neg, vy_neg;
  logic                  sx_in, sy_in;
  logic signed [CW-1:0]  cx_in, cy_in;
  logic [COORD_W-1:0]    avx, avy;
  logic signed [PW-1:0]  bx_pos, by_pos, ax_full, ay_full, ax_neg, ay_neg;
  logic [QW-1:0]         ax, ay;
  logic signed [CMPW-1:0] cx_ext, cy_ext, w_lim, h_lim;
  logic                  oob;

  assign vx_in  = VW'(to_x_i) - VW'(from_x_i);
  assign vy_in  = VW'(to_y_i) - VW'(from_y_i);
  assign sx_in  = !vx_in[VW-1] && (|vx_in);
  assign sy_in  = !vy_in[VW-1] && (|vy_in);
  assign cx_in  = CW'(from_x_i >> FRAC_BITS);
  assign cy_in  = CW'(from_y_i >> FRAC_BITS);

  assign vx_neg = -vx_q;
  assign vy_neg = -vy_q;
  assign avx    = vx_q[VW-1] ? vx_neg[COORD_W-1:0] : vx_q[COORD_W-1:0];
  assign avy    = vy_q[VW-1] ? vy_neg[COORD_W-1:0] : vy_q[COORD_W-1:0];

  assign bx_pos  = PW'(bx_q) <<< FRAC_BITS;
  assign by_pos  = PW'(by_q) <<< FRAC_BITS;
  assign ax_full = bx_pos - px_q;
  assign ay_full = by_pos - py_q;
  assign ax_neg  = -ax_full;
  assign ay_neg  = -ay_full;
  assign ax      = ax_full[PW-1] ? ax_neg[QW-1:0] : ax_full[QW-1:0];
  assign ay      = ay_full[PW-1] ? ay_neg[QW-1:0] : ay_full[QW-1:0];

  assign cx_ext = CMPW'(cx_q);
  assign cy_ext = CMPW'(cy_q);
  assign w_lim  = (CMPW'(map_width_q) > CMPW'(MAP_SIDE)) ? CMPW'(MAP_SIDE)
                                                         : CMPW'(map_width_q);
  assign h_lim  = (CMPW'(map_height_q) > CMPW'(MAP_SIDE)) ? CMPW'(MAP_SIDE)
                                                          : CMPW'(map_height_q);
  assign oob    = cx_ext[CMPW-1] || cy_ext[CMPW-1] || (cx_ext >= w_lim) ||
                  (cy_ext >= h_lim);
  assign mem_ra = {cy_ext[AW-1:0], cx_ext[AW-1:0]};

  // shared multiplier
  logic signed [MW-1:0]  mul_a, mul_b, dx, dy;
  logic signed [PRW-1:0] prod_q, acc_q, len_q, dist_sum;

  assign dx = MW'(px_q) - MW'(fx_q);
  assign dy = MW'(py_q) - MW'(fy_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_VX: begin mul_a = MW'(vx_q); mul_b = MW'(vx_q); end
      MUL_VY: begin mul_a = MW'(vy_q); mul_b = MW'(vy_q); end
      MUL_DX: begin mul_a = dx; mul_b = dx; end
      MUL_DY: begin mul_a = dy; mul_b = dy; end
      MUL_XA: begin mul_a = MW'(avx); mul_b = MW'(ay); end
      MUL_YA: begin mul_a = MW'(avy); mul_b = MW'(ax); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign dist_sum = acc_q + prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.acc_ld) acc_q <= prod_q;
    if (cmd_i.len_ld) len_q <= dist_sum;
  end

  // step divider, one quotient bit a cycle
  logic                  step_x_q, step_x_d;
  logic [NW-1:0]         num;
  logic [COORD_W-1:0]    den_q, rem_q, rem_sub;
  logic [QW-1:0]         nq_q;
  logic [DCW-1:0]        div_cnt_q;
  logic [COORD_W:0]      trial, trial_sub;
  logic                  ge;
  logic signed [PW-1:0]  q_ext;

  assign step_x_d  = (vy_q == '0) || (acc_q > prod_q);
  assign num       = step_x_d ? prod_q[NW-1:0] : acc_q[NW-1:0];
  assign trial     = {rem_q, nq_q[QW-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  assign rem_sub   = ge ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
  assign q_ext     = PW'(nq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld) begin
      step_x_q  <= step_x_d;
      den_q     <= step_x_d ? avx : avy;
      rem_q     <= num[NW-1:QW];
      nq_q      <= num[QW-1:0];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_sub;
      nq_q      <= {nq_q[QW-2:0], ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      fx_q <= PW'(from_x_i);
      fy_q <= PW'(from_y_i);
      px_q <= PW'(from_x_i);
      py_q <= PW'(from_y_i);
      tx_q <= to_x_i;
      ty_q <= to_y_i;
      vx_q <= vx_in;
      vy_q <= vy_in;
      sx_q <= sx_in;
      sy_q <= sy_in;
      cx_q <= cx_in;
      cy_q <= cy_in;
      bx_q <= sx_in ? cx_in + ONE_C : cx_in;
      by_q <= sy_in ? cy_in + ONE_C : cy_in;
    end else if (cmd_i.upd) begin
      if (step_x_q) begin
        py_q <= sy_q ? py_q + q_ext : py_q - q_ext;
        px_q <= bx_pos;
        cx_q <= cx_q + (sx_q ? ONE_C : NEG_C);
        bx_q <= bx_q + (sx_q ? ONE_C : NEG_C);
      end else begin
        px_q <= sx_q ? px_q + q_ext : px_q - q_ext;
        py_q <= by_pos;
        cy_q <= cy_q + (sy_q ? ONE_C : NEG_C);
        by_q <= by_q + (sy_q ? ONE_C : NEG_C);
      end
    end
  end

  // result register
  logic               hit_q;
  logic [COORD_W-1:0] end_x_q, end_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      hit_q   <= cmd_i.out_hit;
      end_x_q <= cmd_i.out_hit ? clamp16(px_q) : tx_q;
      end_y_q <= cmd_i.out_hit ? clamp16(py_q) : ty_q;
    end
  end

  assign hit_o   = hit_q;
  assign end_x_o = end_x_q;
  assign end_y_o = end_y_q;

  assign status_o.clear_done = (clr_cnt_q == '1);
  assign status_o.dist_ok    = dist_sum < len_q;
  assign status_o.wall       = oob || mem_rd_q;
  assign status_o.div_done   = (div_cnt_q == DCW'(FRAC_BITS));

endmodule

// ===== rtl/grid_ray_wall_hit.sv =====
// top level: traces segments through a wall bitmap and reports the first hit
//
//   channel  signals                                         direction
//   in       in_valid_i/in_stall_o, operation_i, cell_*, from_*, to_*   request in
//   out      out_valid_o/out_stall_i, hit_o, end_x_o, end_y_o    result out
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i                 register write
//
// a map write is done in the idle state; a trace runs a length pass, then cell steps
// until a distance check finds a wall, the map edge or the end point, where a cell
// step is a distance multiplier pass, a comparison multiplier pass, the divider and one update;
// the next request is taken once the result is loaded; after reset a clearing pass writes
// all 2^(2*clog2(MAP_SIDE)) memory entries (4096 by default); requests stall until it ends
// a finished result waits in the output register while the next request starts
module grid_ray_wall_hit import grw_pkg::*; #(
  parameter int unsigned MAP_SIDE  = MAP_SIDE_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [CELL_W-1:0]  cell_x_i,
  input  logic [CELL_W-1:0]  cell_y_i,
  input  logic               cell_blocked_i,
  input  logic [COORD_W-1:0] from_x_i,
  input  logic [COORD_W-1:0] from_y_i,
  input  logic [COORD_W-1:0] to_x_i,
  input  logic [COORD_W-1:0] to_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [COORD_W-1:0] end_x_o,
  output logic [COORD_W-1:0] end_y_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  grw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  grw_datapath #(
    .MAP_SIDE  (MAP_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_blocked_i (cell_blocked_i),
    .from_x_i       (from_x_i),
    .from_y_i       (from_y_i),
    .to_x_i         (to_x_i),
    .to_y_i         (to_y_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .hit_o          (hit_o),
    .end_x_o        (end_x_o),
    .end_y_o        (end_y_o)
  );

endmodule
